// ===== rtl/lqg_pkg.sv =====
// Package for the LQG speed regulator with six-step commutation.
// Holds payload structs, register indexes, the transition matrix, the
// commutation table and the controller-to-datapath command struct. No dependencies.
package lqg_pkg;

    localparam int STATE_FRAC_BITS = 24;
    localparam int GAIN_FRAC_BITS  = 30;
    localparam int TRANS_FRAC_BITS = 30;
    localparam int ERR_SHIFT       = 16 + GAIN_FRAC_BITS - STATE_FRAC_BITS;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] encoder_count;
        logic signed [31:0] speed_setpoint;
        logic        [2:0]  hall_state;
    } in_item_t;

    typedef struct packed {
        logic [15:0] phase_a_high;
        logic [15:0] phase_a_low;
        logic [15:0] phase_b_high;
        logic [15:0] phase_b_low;
        logic [15:0] phase_c_high;
        logic [15:0] phase_c_low;
        logic        drive_direction;
        logic        hall_valid;
    } out_item_t;

    localparam logic [2:0] REG_PWM_PERIOD  = 3'd0;
    localparam logic [2:0] REG_COUNT_SCALE = 3'd1;
    localparam logic [2:0] REG_OBS_GAIN_0  = 3'd2;
    localparam logic [2:0] REG_OBS_GAIN_1  = 3'd3;
    localparam logic [2:0] REG_OBS_GAIN_2  = 3'd4;
    localparam logic [2:0] REG_FB_GAIN_0   = 3'd5;
    localparam logic [2:0] REG_FB_GAIN_1   = 3'd6;
    localparam logic [2:0] REG_FB_GAIN_2   = 3'd7;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_HALL = 1'b1;

    // Multiplier operand selections.
    typedef enum logic [2:0] {
        MS_ERR   = 3'd0,
        MS_TRANS = 3'd1,
        MS_OBS   = 3'd2,
        MS_FB    = 3'd3,
        MS_DUTY  = 3'd4
    } mul_sel_t;

    // Command from controller to datapath.
    typedef struct packed {
        logic       load;       // capture input item
        logic       mul_go;     // register a product this cycle
        mul_sel_t   sel;
        logic [1:0] row;
        logic [1:0] col;
        logic       acc_clr;    // clear both accumulators
        logic       acc_add;    // take last product into error or accumulators
        logic       row_done;   // form estimate row from accumulators
        logic       cmd_done;   // form drive command
        logic       commit;     // write estimate
        logic       duty_done;  // form output item
    } dp_cmd_t;

    function automatic logic signed [31:0] trans_coef(input logic [1:0] r, input logic [1:0] c);
        logic signed [31:0] v;
        begin
            v = 32'sd0;
            case ({r, c})
                4'b0000: v = 32'sd820231379;
                4'b0001: v = -32'sd384399573;
                4'b0010: v = -32'sd562962838;
                4'b0100: v = 32'sd295493750;
                4'b0101: v = -32'sd157947422;
                4'b0110: v = -32'sd590558003;
                4'b1000: v = -32'sd278313881;
                4'b1001: v = 32'sd468688306;
                4'b1010: v = 32'sd702871398;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

    // Returns a six-bit mask of the active duty slots; zero for invalid hall.
    // Bit 0 A high, 1 A low, 2 B high, 3 B low, 4 C high, 5 C low.
    function automatic logic [5:0] comm_mask(input logic dir, input logic [2:0] hall);
        logic [5:0] m;
        begin
            m = 6'b000000;
            case ({dir, hall})
                4'b0001: m = 6'b011000;
                4'b0010: m = 6'b000110;
                4'b0011: m = 6'b010010;
                4'b0100: m = 6'b100001;
                4'b0101: m = 6'b001001;
                4'b0110: m = 6'b100100;
                4'b1001: m = 6'b100100;
                4'b1010: m = 6'b001001;
                4'b1011: m = 6'b100001;
                4'b1100: m = 6'b010010;
                4'b1101: m = 6'b000110;
                4'b1110: m = 6'b011000;
                default: m = 6'b000000;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== rtl/lqg_speed_loop_six_step_commutator.sv =====
// LQG speed regulator with six-step commutation: top level.
// A control tick runs 17 shared-multiplier products and accumulations from transfer in
// to result, a hall event only the duty product; one item at a time.
// rst_n clears estimate, command, held duties and loads register defaults.
// Depends on lqg_pkg, lqg_controller and lqg_datapath.
module lqg_speed_loop_six_step_commutator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lqg_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output lqg_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    lqg_pkg::dp_cmd_t cmd;
    logic             is_tick;

    assign cfg_ready = 1'b1;

    lqg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_tick   (is_tick),
        .cmd       (cmd)
    );

    lqg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .is_tick   (is_tick),
        .result    (out_data)
    );

endmodule

// ===== rtl/lqg_datapath.sv =====
// Datapath of the LQG regulator: one shared 33x33 multiplier, two accumulators,
// estimate and gain registers, and output formation. Depends on lqg_pkg.
module lqg_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lqg_pkg::dp_cmd_t    cmd,
    input  lqg_pkg::in_item_t   in_item,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                is_tick,
    output lqg_pkg::out_item_t  result
);

    logic [15:0]        pwm_period_reg;
    logic [23:0]        count_scale_reg;
    logic signed [31:0] obs_gain_reg [3];
    logic signed [31:0] fb_gain_reg  [3];
    logic signed [31:0] est_reg      [3];
    logic signed [31:0] next_reg     [3];
    logic signed [31:0] u_reg;
    logic signed [31:0] err_reg;
    logic [15:0]        held_reg     [6];
    lqg_pkg::in_item_t  item_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [65:0] acc2_reg;
    lqg_pkg::out_item_t result_reg;

    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [31:0] mag_u;

    logic [5:0]  duty_mask;
    logic [15:0] duty_val;
    logic [65 - lqg_pkg::STATE_FRAC_BITS:0] duty_raw;
    logic [15:0] held_new [6];

    assign is_tick = (item_reg.opcode == lqg_pkg::OP_TICK);
    assign result  = result_reg;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // Copy of the command; its magnitude is taken in 33 bits, where |INT_MIN| fits.
    assign mag_u = u_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.sel)
            lqg_pkg::MS_ERR:
            begin
                op_a = 33'(signed'(item_reg.encoder_count));
                op_b = {9'd0, count_scale_reg};
            end
            lqg_pkg::MS_TRANS:
            begin
                op_a = 33'(lqg_pkg::trans_coef(cmd.row, cmd.col));
                op_b = 33'(est_reg[cmd.col]);
            end
            lqg_pkg::MS_OBS:
            begin
                op_a = 33'(obs_gain_reg[cmd.row]);
                op_b = 33'(err_reg);
            end
            lqg_pkg::MS_FB:
            begin
                op_a = 33'(fb_gain_reg[cmd.row]);
                op_b = 33'(next_reg[cmd.row]);
            end
            lqg_pkg::MS_DUTY:
            begin
                op_a = mag_u[31] ? -33'(mag_u) : 33'(mag_u);
                op_b = {17'd0, pwm_period_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg  <= 16'd1000;
            count_scale_reg <= 24'd2412984;
            obs_gain_reg[0] <= 32'sd305909;
            obs_gain_reg[1] <= -32'sd89904;
            obs_gain_reg[2] <= -32'sd1306744;
            fb_gain_reg[0]  <= -32'sd444206993;
            fb_gain_reg[1]  <= -32'sd730681311;
            fb_gain_reg[2]  <= 32'sd798863917;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lqg_pkg::REG_PWM_PERIOD:  pwm_period_reg  <= cfg_data[15:0];
                lqg_pkg::REG_COUNT_SCALE: count_scale_reg <= cfg_data[23:0];
                lqg_pkg::REG_OBS_GAIN_0:  obs_gain_reg[0] <= cfg_data;
                lqg_pkg::REG_OBS_GAIN_1:  obs_gain_reg[1] <= cfg_data;
                lqg_pkg::REG_OBS_GAIN_2:  obs_gain_reg[2] <= cfg_data;
                lqg_pkg::REG_FB_GAIN_0:   fb_gain_reg[0]  <= cfg_data;
                lqg_pkg::REG_FB_GAIN_1:   fb_gain_reg[1]  <= cfg_data;
                lqg_pkg::REG_FB_GAIN_2:   fb_gain_reg[2]  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Item capture, product register and accumulators.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.mul_go)
            prod_reg <= op_a * op_b;
        if (cmd.acc_clr)
        begin
            acc_reg  <= '0;
            acc2_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            unique case (cmd.sel)
                lqg_pkg::MS_ERR:
                    err_reg <= sat32(prod_reg - 66'(item_reg.speed_setpoint));
                lqg_pkg::MS_TRANS: acc_reg <= acc_reg + prod_reg;
                lqg_pkg::MS_OBS:   acc2_reg <= prod_reg;
                lqg_pkg::MS_FB:
                    acc_reg <= acc_reg
                        + ((prod_reg + (66'sd1 <<< (lqg_pkg::GAIN_FRAC_BITS - 1)))
                           >>> lqg_pkg::GAIN_FRAC_BITS);
                default: ;
            endcase
        end
        if (cmd.row_done)
            next_reg[cmd.row] <= sat32(
                ((acc_reg + (66'sd1 <<< (lqg_pkg::TRANS_FRAC_BITS - 1)))
                 >>> lqg_pkg::TRANS_FRAC_BITS)
              + ((acc2_reg + (66'sd1 <<< (lqg_pkg::ERR_SHIFT - 1)))
                 >>> lqg_pkg::ERR_SHIFT));
    end

    // Architectural state: estimate, command and held duties.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                est_reg[i] <= '0;
            for (int i = 0; i < 6; i++)
                held_reg[i] <= '0;
            u_reg <= '0;
        end
        else
        begin
            if (cmd.commit)
                for (int i = 0; i < 3; i++)
                    est_reg[i] <= next_reg[i];
            if (cmd.cmd_done)
                u_reg <= sat32(-acc_reg);
            if (cmd.duty_done)
            begin
                for (int i = 0; i < 6; i++)
                    if (duty_mask != 6'd0)
                        held_reg[i] <= duty_mask[i] ? duty_val : 16'd0;
            end
        end
    end

    // Duty formation from the registered product.
    always_comb
    begin
        duty_raw  = prod_reg[65:lqg_pkg::STATE_FRAC_BITS];
        duty_mask = lqg_pkg::comm_mask(u_reg[31], item_reg.hall_state);
        if (duty_raw > (66 - lqg_pkg::STATE_FRAC_BITS)'(pwm_period_reg))
            duty_val = pwm_period_reg;
        else
            duty_val = duty_raw[15:0];
        for (int i = 0; i < 6; i++)
            held_new[i] = (duty_mask == 6'd0) ? held_reg[i]
                        : (duty_mask[i] ? duty_val : 16'd0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.duty_done)
        begin
            result_reg.phase_a_high    <= held_new[0];
            result_reg.phase_a_low     <= held_new[1];
            result_reg.phase_b_high    <= held_new[2];
            result_reg.phase_b_low     <= held_new[3];
            result_reg.phase_c_high    <= held_new[4];
            result_reg.phase_c_low     <= held_new[5];
            result_reg.drive_direction <= u_reg[31];
            result_reg.hall_valid      <= (duty_mask != 6'd0);
        end
    end

endmodule

// ===== rtl/lqg_controller.sv =====
// Sequencer for the LQG regulator: steps the shared multiplier through the
// error, estimate, command and duty products. Depends on lqg_pkg.
module lqg_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  logic             is_tick,
    output lqg_pkg::dp_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_ERR   = 8'b00000010,
        S_TRANS = 8'b00000100,
        S_OBS   = 8'b00001000,
        S_ROW   = 8'b00010000,
        S_FB    = 8'b00100000,
        S_DUTY  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic       ph_reg, ph_next;   // 0 multiply, 1 accumulate
    logic       out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;
    // Accept only when idle and the output slot will be free.
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ph_next        = ph_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.sel        = lqg_pkg::MS_ERR;
        cmd.row        = row_reg;
        cmd.col        = col_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ERR;
                    ph_next    = 1'b0;
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                end
            end
            S_ERR:
            begin
                cmd.sel = lqg_pkg::MS_ERR;
                if (!is_tick)
                    state_next = S_DUTY;
                else if (!ph_reg)
                begin
                    cmd.mul_go = 1'b1;
                    ph_next    = 1'b1;
                end
                else
                begin
                    cmd.acc_add = 1'b1;
                    ph_next     = 1'b0;
                    state_next  = S_TRANS;
                end
            end
            S_TRANS:
            begin
                cmd.sel = lqg_pkg::MS_TRANS;
                if (!ph_reg)
                begin
                    if (col_reg == 2'd0)
                        cmd.acc_clr = 1'b1;
                    cmd.mul_go = 1'b1;
                    ph_next    = 1'b1;
                end
                else
                begin
                    cmd.acc_add = 1'b1;
                    ph_next     = 1'b0;
                    if (col_reg == 2'd2)
                    begin
                        col_next   = 2'd0;
                        state_next = S_OBS;
                    end
                    else
                        col_next = col_reg + 2'd1;
                end
            end
            S_OBS:
            begin
                cmd.sel = lqg_pkg::MS_OBS;
                if (!ph_reg)
                begin
                    cmd.mul_go = 1'b1;
                    ph_next    = 1'b1;
                end
                else
                begin
                    cmd.acc_add = 1'b1;
                    ph_next     = 1'b0;
                    state_next  = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.row_done = 1'b1;
                if (row_reg == 2'd2)
                begin
                    row_next   = 2'd0;
                    state_next = S_FB;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = S_TRANS;
                end
            end
            S_FB:
            begin
                cmd.sel = lqg_pkg::MS_FB;
                if (!ph_reg)
                begin
                    if (row_reg == 2'd0)
                        cmd.acc_clr = 1'b1;
                    cmd.mul_go = 1'b1;
                    ph_next    = 1'b1;
                end
                else
                begin
                    cmd.acc_add = 1'b1;
                    ph_next     = 1'b0;
                    if (row_reg == 2'd2)
                    begin
                        row_next   = 2'd0;
                        state_next = S_DUTY;
                        ph_next    = 1'b1;
                    end
                    else
                        row_next = row_reg + 2'd1;
                end
            end
            S_DUTY:
            begin
                cmd.sel = lqg_pkg::MS_DUTY;
                if (ph_reg)
                begin
                    // Command and estimate settle before the duty product.
                    if (is_tick)
                    begin
                        cmd.cmd_done = 1'b1;
                        cmd.commit   = 1'b1;
                    end
                    ph_next = 1'b0;
                end
                else
                begin
                    cmd.mul_go = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.duty_done  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            ph_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new item is never taken while a result still waits on a stall.
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> in_stall)
        else $error("item accepted while output blocked");
    // A result is presented in the cycle after the output state.
    a_out_after_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> out_valid_reg)
        else $error("result not presented after duty");
    // Row and column counters stay within the matrix.
    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg != 2'd3) && (col_reg != 2'd3))
        else $error("matrix counter out of range");

endmodule

// ===== dv/tb_lqg_speed_loop_six_step_commutator.sv =====
// Self-checking testbench for the LQG speed regulator with six-step commutation.
// Drives ticks, hall events and register writes and compares every result against
// a built-in predictor. Depends on lqg_pkg and lqg_speed_loop_six_step_commutator.
module tb_lqg_speed_loop_six_step_commutator;

    localparam int  IDLE_LIMIT   = 5000;
    localparam int  DRAIN_CYCLES = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    lqg_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    lqg_pkg::out_item_t out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    // Predictor state and registers.
    logic [15:0]        pwm_period;
    logic [23:0]        count_scale;
    logic signed [31:0] obs_gain [3];
    logic signed [31:0] fb_gain [3];
    logic signed [31:0] estimate [3];
    logic signed [31:0] drive_cmd;
    logic [15:0]        held_duty [6];

    lqg_pkg::out_item_t expected_duties [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          tick_count = 0;
    int          hall_count = 0;
    int          cfg_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_hold = 0;

    localparam longint TRANS [9] = '{
        64'sd820231379, -64'sd384399573, -64'sd562962838,
        64'sd295493750, -64'sd157947422, -64'sd590558003,
        -64'sd278313881, 64'sd468688306, 64'sd702871398
    };

    // Active duty slots per direction and hall pattern; slot 0 is A high, 5 is C low.
    localparam logic [5:0] SLOTS [2][8] = '{
        '{6'b000000, 6'b011000, 6'b000110, 6'b010010,
          6'b100001, 6'b001001, 6'b100100, 6'b000000},
        '{6'b000000, 6'b100100, 6'b001001, 6'b100001,
          6'b010010, 6'b000110, 6'b011000, 6'b000000}
    };

    lqg_speed_loop_six_step_commutator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void reset_model();
        pwm_period  = 16'd1000;
        count_scale = 24'd2412984;
        obs_gain[0] = 32'sd305909;
        obs_gain[1] = -32'sd89904;
        obs_gain[2] = -32'sd1306744;
        fb_gain[0]  = -32'sd444206993;
        fb_gain[1]  = -32'sd730681311;
        fb_gain[2]  = 32'sd798863917;
        drive_cmd   = '0;
        for (int i = 0; i < 3; i++)
            estimate[i] = '0;
        for (int i = 0; i < 6; i++)
            held_duty[i] = '0;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            lqg_pkg::REG_PWM_PERIOD:  pwm_period  = val[15:0];
            lqg_pkg::REG_COUNT_SCALE: count_scale = val[23:0];
            lqg_pkg::REG_OBS_GAIN_0:  obs_gain[0] = val;
            lqg_pkg::REG_OBS_GAIN_1:  obs_gain[1] = val;
            lqg_pkg::REG_OBS_GAIN_2:  obs_gain[2] = val;
            lqg_pkg::REG_FB_GAIN_0:   fb_gain[0]  = val;
            lqg_pkg::REG_FB_GAIN_1:   fb_gain[1]  = val;
            lqg_pkg::REG_FB_GAIN_2:   fb_gain[2]  = val;
            default: ;
        endcase
    endfunction

    // Advances the regulator on a tick and commutates the stored drive command.
    function automatic lqg_pkg::out_item_t predict_duties(input lqg_pkg::in_item_t it);
        longint    err;
        longint    s;
        longint    acc;
        longint    next_est [3];
        longint    mag;
        longint    duty;
        logic      dir;
        logic [5:0] mask;
        lqg_pkg::out_item_t r;
        if (it.opcode == lqg_pkg::OP_TICK)
        begin
            err = sat32(longint'(it.encoder_count) * longint'(count_scale)
                        - longint'(it.speed_setpoint));
            for (int i = 0; i < 3; i++)
            begin
                s = 0;
                for (int j = 0; j < 3; j++)
                    s += TRANS[3 * i + j] * longint'(estimate[j]);
                next_est[i] = sat32(round_shift(s, lqg_pkg::TRANS_FRAC_BITS)
                                    + round_shift(longint'(obs_gain[i]) * err,
                                                  lqg_pkg::ERR_SHIFT));
            end
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                estimate[i] = next_est[i][31:0];
                acc += round_shift(longint'(fb_gain[i]) * next_est[i],
                                   lqg_pkg::GAIN_FRAC_BITS);
            end
            drive_cmd = 32'(sat32(-acc));
        end
        dir  = drive_cmd < 0;
        mag  = dir ? -longint'(drive_cmd) : longint'(drive_cmd);
        duty = (mag * longint'(pwm_period)) >>> lqg_pkg::STATE_FRAC_BITS;
        if (duty > longint'(pwm_period))
            duty = longint'(pwm_period);
        mask = SLOTS[dir][it.hall_state];
        if (mask != 0)
        begin
            for (int i = 0; i < 6; i++)
                held_duty[i] = mask[i] ? duty[15:0] : 16'd0;
        end
        r.phase_a_high    = held_duty[0];
        r.phase_a_low     = held_duty[1];
        r.phase_b_high    = held_duty[2];
        r.phase_b_low     = held_duty[3];
        r.phase_c_high    = held_duty[4];
        r.phase_c_low     = held_duty[5];
        r.drive_direction = dir;
        r.hall_valid      = mask != 0;
        return r;
    endfunction

    function automatic void compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Transfers on all three channels are observed at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
                idle_cycles = 0;
            end
            if (in_valid && !in_stall)
            begin
                expected_duties.push_back(predict_duties(in_data));
                idle_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                if (expected_duties.size() == 0)
                begin
                    $error("result transfer with no expected result");
                    error_count++;
                end
                else
                begin
                    lqg_pkg::out_item_t e;
                    e = expected_duties.pop_front();
                    compare_field("phase_a_high", e.phase_a_high, out_data.phase_a_high);
                    compare_field("phase_a_low", e.phase_a_low, out_data.phase_a_low);
                    compare_field("phase_b_high", e.phase_b_high, out_data.phase_b_high);
                    compare_field("phase_b_low", e.phase_b_low, out_data.phase_b_low);
                    compare_field("phase_c_high", e.phase_c_high, out_data.phase_c_high);
                    compare_field("phase_c_low", e.phase_c_low, out_data.phase_c_low);
                    compare_field("drive_direction", e.drive_direction,
                                  out_data.drive_direction);
                    compare_field("hall_valid", e.hall_valid, out_data.hall_valid);
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("lqg_speed_loop_six_step_commutator: mismatch");
                $finish;
            end
        end
    end

    // Result side: random stalls plus an optional long hold-off.
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold--;
            out_stall = 1'b1;
        end
        else
            out_stall = $urandom_range(99) < recv_idle_pct;
    end

    task automatic send_item(input lqg_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do
            @(posedge clk);
        while (in_stall);
        if (it.opcode == lqg_pkg::OP_TICK)
            tick_count++;
        else
            hall_count++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_tick(input logic signed [15:0] cnt, input logic signed [31:0] sp,
                             input logic [2:0] hall);
        lqg_pkg::in_item_t it;
        it.opcode = lqg_pkg::OP_TICK;
        it.encoder_count = cnt;
        it.speed_setpoint = sp;
        it.hall_state = hall;
        send_item(it);
    endtask

    task automatic send_hall(input logic [2:0] hall);
        lqg_pkg::in_item_t it;
        it.opcode = lqg_pkg::OP_HALL;
        it.encoder_count = 16'($urandom);
        it.speed_setpoint = $urandom;
        it.hall_state = hall;
        send_item(it);
    endtask

    task automatic wait_drained();
        while (expected_duties.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_count++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_defaults();
        write_reg(lqg_pkg::REG_PWM_PERIOD, 32'd1000);
        write_reg(lqg_pkg::REG_COUNT_SCALE, 32'd2412984);
        write_reg(lqg_pkg::REG_OBS_GAIN_0, 32'sd305909);
        write_reg(lqg_pkg::REG_OBS_GAIN_1, -32'sd89904);
        write_reg(lqg_pkg::REG_OBS_GAIN_2, -32'sd1306744);
        write_reg(lqg_pkg::REG_FB_GAIN_0, -32'sd444206993);
        write_reg(lqg_pkg::REG_FB_GAIN_1, -32'sd730681311);
        write_reg(lqg_pkg::REG_FB_GAIN_2, 32'sd798863917);
    endtask

    // Random items: mostly ticks with moderate speeds, some hall events and wild values.
    task automatic run_random(input int n);
        logic signed [15:0] cnt;
        logic signed [31:0] sp;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 30)
                send_hall(3'($urandom_range(7)));
            else
            begin
                if ($urandom_range(99) < 70)
                begin
                    cnt = $signed(16'($urandom_range(40))) - 16'sd20;
                    sp  = $signed(32'($urandom_range(32'h0100_0000))) - 32'sh0080_0000;
                end
                else
                begin
                    cnt = 16'($urandom);
                    sp  = $urandom;
                end
                send_tick(cnt, sp, 3'($urandom_range(7)));
            end
        end
    endtask

    task automatic test_directed();
        send_tick(16'sd0, 32'sd0, 3'd1);
        send_tick(16'sh7FFF, 32'sh8000_0000, 3'd2);
        send_tick(-16'sh8000, 32'sh7FFF_FFFF, 3'd3);
        send_tick(16'sd5, 32'sd0, 3'd0);
        send_tick(-16'sd5, 32'sd0, 3'd7);
        for (int h = 0; h < 8; h++)
            send_hall(h[2:0]);
        send_tick(16'sh7FFF, 32'sh8000_0000, 3'd4);
        for (int h = 1; h < 7; h++)
            send_hall(h[2:0]);
        send_tick(-16'sh8000, 32'sh7FFF_FFFF, 3'd5);
        send_tick(16'sd0, 32'sh7FFF_FFFF, 3'd6);
        send_hall(3'd0);
        send_hall(3'd7);
    endtask

    task automatic test_register_extremes();
        write_reg(lqg_pkg::REG_PWM_PERIOD, 32'd65535);
        write_reg(lqg_pkg::REG_COUNT_SCALE, 32'hFF_FFFF);
        write_reg(lqg_pkg::REG_OBS_GAIN_0, 32'sh7FFF_FFFF);
        write_reg(lqg_pkg::REG_OBS_GAIN_1, 32'sh8000_0000);
        write_reg(lqg_pkg::REG_OBS_GAIN_2, 32'sh7FFF_FFFF);
        write_reg(lqg_pkg::REG_FB_GAIN_0, 32'sh8000_0000);
        write_reg(lqg_pkg::REG_FB_GAIN_1, 32'sh7FFF_FFFF);
        write_reg(lqg_pkg::REG_FB_GAIN_2, 32'sh8000_0000);
        run_random(60);
        // A zero period forces every newly formed duty to zero.
        write_reg(lqg_pkg::REG_PWM_PERIOD, 32'd0);
        write_reg(lqg_pkg::REG_COUNT_SCALE, 32'd0);
        run_random(30);
        write_reg(lqg_pkg::REG_PWM_PERIOD, 32'd1);
        run_random(30);
    endtask

    task automatic test_random_gains();
        write_reg(lqg_pkg::REG_PWM_PERIOD, $urandom_range(65535, 1));
        write_reg(lqg_pkg::REG_COUNT_SCALE, $urandom_range(24'hFF_FFFF));
        for (int i = 0; i < 3; i++)
            write_reg(lqg_pkg::REG_OBS_GAIN_0 + 3'(i),
                      $signed(32'($urandom_range(4000000))) - 2000000);
        for (int i = 0; i < 3; i++)
            write_reg(lqg_pkg::REG_FB_GAIN_0 + 3'(i), $urandom);
        run_random(150);
    endtask

    task automatic test_backpressure();
        fork
            recv_hold = 300;
            run_random(20);
        join
        wait_drained();
        run_random(20);
    endtask

    initial
    begin
        reset_model();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 60;
        test_directed();
        run_random(400);
        test_backpressure();
        send_idle_pct = 60;
        recv_idle_pct = 37;
        test_register_extremes();
        test_random_gains();
        write_defaults();
        run_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_gains();
        write_defaults();
        run_random(350);

        wait_drained();
        $display("Covered %0d control ticks and %0d hall events over %0d register writes,",
                 tick_count, hall_count, cfg_count);
        $display("with both sides stalling in turn and a long output hold-off.");
        if (error_count == 0)
            $display("lqg_speed_loop_six_step_commutator: match");
        else
            $display("lqg_speed_loop_six_step_commutator: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lqg_pkg.sv
rtl/lqg_datapath.sv
rtl/lqg_controller.sv
rtl/lqg_speed_loop_six_step_commutator.sv
dv/tb_lqg_speed_loop_six_step_commutator.sv
